/* hdl/olst_pkg.sv */
package olst_pkg;

   // Storage geometry.
   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;

   // Field widths fixed by the request and response formats.
   localparam int TYPE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int STAT_W   = 2;
   localparam int FIDX_W   = 6;
   localparam int FCNT_W   = 7;

   // Internal widths derived from the geometry.
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Request codes.
   typedef enum logic [TYPE_W-1:0] {
      REQ_INS_FRONT = 3'd0,
      REQ_INS_END   = 3'd1,
      REQ_INS_AFTER = 3'd2,
      REQ_DEL_FRONT = 3'd3,
      REQ_DEL_END   = 3'd4,
      REQ_DEL_IDX   = 3'd5,
      REQ_DEL_MATCH = 3'd6,
      REQ_SEARCH    = 3'd7
   } req_code_type;

   // Status codes.
   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_MISS  = 2'd3
   } status_type;

   // Memory port commands from the sequencer.
   typedef struct packed {
      logic                  we;
      logic [IDX_W-1:0]      waddr;
      logic [DATA_WIDTH-1:0] wdata;
      logic                  re;
      logic [IDX_W-1:0]      raddr;
   } ram_req_type;

   // Sequencer status seen by the top level.
   typedef struct packed {
      logic             idle;
      logic [CNT_W-1:0] count;
   } ctrl_stat_type;

   // One response as held in the output register.
   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [VALUE_W-1:0] data;
      logic [FIDX_W-1:0]  found_index;
      logic [FCNT_W-1:0]  count;
      logic               last;
   } rsp_payload_type;

   // Sign-extend a request value into a stored word.
   function automatic logic [DATA_WIDTH-1:0] make_word(input logic [VALUE_W-1:0] v);
      logic [63:0] ext;
      ext = {{(64-VALUE_W){v[VALUE_W-1]}}, v};
      return ext[DATA_WIDTH-1:0];
   endfunction

   // The data field is the low bits of the stored word.
   function automatic logic [VALUE_W-1:0] word_to_data(input logic [DATA_WIDTH-1:0] w);
      logic [DATA_WIDTH+VALUE_W-1:0] t;
      t = {{VALUE_W{1'b0}}, w};
      return t[VALUE_W-1:0];
   endfunction

   // The index field is the low bits of the list index.
   function automatic logic [FIDX_W-1:0] index_out(input logic [IDX_W-1:0] i);
      logic [IDX_W+FIDX_W-1:0] t;
      t = {{FIDX_W{1'b0}}, i};
      return t[FIDX_W-1:0];
   endfunction

   // The count field is the low bits of the element count.
   function automatic logic [FCNT_W-1:0] count_out(input logic [CNT_W-1:0] c);
      logic [CNT_W+FCNT_W-1:0] t;
      t = {{FCNT_W{1'b0}}, c};
      return t[FCNT_W-1:0];
   endfunction

endpackage

/* hdl/olst_req_if.sv */
interface olst_req_if;
   import olst_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [TYPE_W-1:0]         req_type;
   logic signed [VALUE_W-1:0] value;
   logic [POS_W-1:0]          position;
   logic                      read_all;

   modport source (output valid, req_type, value, position, read_all, input ready);
   modport sink   (input valid, req_type, value, position, read_all, output ready);
endinterface

/* hdl/olst_rsp_if.sv */
interface olst_rsp_if;
   import olst_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STAT_W-1:0]         status;
   logic signed [VALUE_W-1:0] data;
   logic [FIDX_W-1:0]         found_index;
   logic [FCNT_W-1:0]         count;
   logic                      last;

   modport source (output valid, status, data, found_index, count, last, input ready);
   modport sink   (input valid, status, data, found_index, count, last, output ready);
endinterface

/* hdl/olst_ram.sv */
module olst_ram #(
   parameter int DEPTH_P = 64,
   parameter int WIDTH_P = 32
) (
   input  logic                                            clock,
   input  logic                                            we,
   input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] waddr,
   input  logic [WIDTH_P-1:0]                              wdata,
   input  logic                                            re,
   input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] raddr,
   output logic [WIDTH_P-1:0]                              rdata
);

   logic [WIDTH_P-1:0] mem [DEPTH_P];
   logic [WIDTH_P-1:0] rdata_ff;

   // One write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // One read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/olst_ctrl.sv */
module olst_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   olst_req_if.sink                        req_if,
   olst_rsp_if.source                      rsp_if,
   output olst_pkg::ram_req_type           ram_req,
   input  logic [olst_pkg::DATA_WIDTH-1:0] ram_rdata,
   output olst_pkg::ctrl_stat_type         stat
);
   import olst_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_INS_SHIFT = 8'b0000_0010,
      S_INS_PUT   = 8'b0000_0100,
      S_DEL_SHIFT = 8'b0000_1000,
      S_SCAN      = 8'b0001_0000,
      S_RD_ISSUE  = 8'b0010_0000,
      S_RD_OUT    = 8'b0100_0000,
      S_RESP      = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   logic [IDX_W-1:0]      at_ff, at_in;
   logic                  issue_ff, issue_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      pend_addr_ff, pend_addr_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [DATA_WIDTH-1:0] removed_ff, removed_in;
   req_code_type          kind_ff, kind_in;
   rsp_payload_type       res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic                  accept;
   logic                  slot_free;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic [CMP_W-1:0]      ins_at;
   logic                  ptr_is_end;
   logic                  full;

   assign accept    = req_if.valid && req_if.ready;
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign pos_ext   = CMP_W'(req_if.position);
   assign cnt_ext   = CMP_W'(count_ff);
   assign full      = (count_ff == CNT_W'(DEPTH));
   // True when the pointer sits on the last held element.
   assign ptr_is_end = ((CNT_W'(ptr_ff) + CNT_W'(1)) == count_ff);

   // Insert position for the three insert requests.
   always_comb begin
      case (req_code_type'(req_if.req_type))
         REQ_INS_FRONT: ins_at = '0;
         REQ_INS_END:   ins_at = cnt_ext;
         default:       ins_at = pos_ext + CMP_W'(1);
      endcase
   end

   // Sequencer: decodes a request, walks the memory, and loads responses.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      at_in        = at_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      word_in      = word_ff;
      removed_in   = removed_ff;
      kind_in      = kind_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_in       = rsp_ff;
      ram_req      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               word_in  = make_word(req_if.value);
               kind_in  = req_code_type'(req_if.req_type);
               res_in   = '0;
               res_in.last = 1'b1;
               issue_in = 1'b1;
               pend_in  = 1'b0;
               if (req_if.read_all) begin
                  if (count_ff == '0) begin
                     res_in.status = STAT_EMPTY;
                     state_in      = S_RESP;
                  end else begin
                     ptr_in   = '0;
                     state_in = S_RD_ISSUE;
                  end
               end else if (req_if.req_type inside {REQ_INS_FRONT, REQ_INS_END,
                                                    REQ_INS_AFTER}) begin
                  if (full) begin
                     res_in.status = STAT_FULL;
                     state_in      = S_RESP;
                  end else if (req_if.req_type == REQ_INS_AFTER && count_ff == '0) begin
                     res_in.status = STAT_EMPTY;
                     state_in      = S_RESP;
                  end else if (req_if.req_type == REQ_INS_AFTER && pos_ext >= cnt_ext) begin
                     res_in.status = STAT_MISS;
                     state_in      = S_RESP;
                  end else begin
                     at_in  = ins_at[IDX_W-1:0];
                     ptr_in = IDX_W'(count_ff - CNT_W'(1));
                     // Appending needs no shift.
                     if (ins_at == cnt_ext) begin
                        state_in = S_INS_PUT;
                     end else begin
                        state_in = S_INS_SHIFT;
                     end
                  end
               end else if (count_ff == '0) begin
                  res_in.status = STAT_EMPTY;
                  state_in      = S_RESP;
               end else begin
                  case (req_code_type'(req_if.req_type))
                     REQ_DEL_FRONT: begin
                        at_in    = '0;
                        ptr_in   = '0;
                        state_in = S_DEL_SHIFT;
                     end
                     REQ_DEL_END: begin
                        at_in    = IDX_W'(count_ff - CNT_W'(1));
                        ptr_in   = IDX_W'(count_ff - CNT_W'(1));
                        state_in = S_DEL_SHIFT;
                     end
                     REQ_DEL_IDX: begin
                        if (pos_ext >= cnt_ext) begin
                           res_in.status = STAT_MISS;
                           state_in      = S_RESP;
                        end else begin
                           at_in    = pos_ext[IDX_W-1:0];
                           ptr_in   = pos_ext[IDX_W-1:0];
                           state_in = S_DEL_SHIFT;
                        end
                     end
                     default: begin
                        ptr_in   = '0;
                        state_in = S_SCAN;
                     end
                  endcase
               end
            end
         end

         // Move entries up by one, from the end down to the insert point.
         S_INS_SHIFT: begin
            if (pend_ff) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = pend_addr_ff + IDX_W'(1);
               ram_req.wdata = ram_rdata;
            end
            if (issue_ff) begin
               ram_req.re    = 1'b1;
               ram_req.raddr = ptr_ff;
               pend_in       = 1'b1;
               pend_addr_in  = ptr_ff;
               if (ptr_ff == at_ff) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff - IDX_W'(1);
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_INS_PUT;
               end
            end
         end

         // Write the new element into the opened gap.
         S_INS_PUT: begin
            ram_req.we         = 1'b1;
            ram_req.waddr      = at_ff;
            ram_req.wdata      = word_ff;
            count_in           = count_ff + CNT_W'(1);
            res_in.status      = STAT_OK;
            res_in.data        = word_to_data(word_ff);
            res_in.found_index = index_out(at_ff);
            state_in           = S_RESP;
         end

         // Read from the delete point to the end; the first word read is the
         // removed one, every later word moves down by one.
         S_DEL_SHIFT: begin
            if (pend_ff) begin
               if (pend_addr_ff == at_ff) begin
                  removed_in = ram_rdata;
               end else begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = pend_addr_ff - IDX_W'(1);
                  ram_req.wdata = ram_rdata;
               end
            end
            if (issue_ff) begin
               ram_req.re    = 1'b1;
               ram_req.raddr = ptr_ff;
               pend_in       = 1'b1;
               pend_addr_in  = ptr_ff;
               if (ptr_is_end) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + IDX_W'(1);
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in           = count_ff - CNT_W'(1);
                  res_in.status      = STAT_OK;
                  res_in.data        = word_to_data(removed_ff);
                  res_in.found_index = index_out(at_ff);
                  state_in           = S_RESP;
               end
            end
         end

         // Linear search for the first match, one read per cycle.
         S_SCAN: begin
            if (pend_ff && ram_rdata == word_ff) begin
               if (kind_ff == REQ_SEARCH) begin
                  res_in.status      = STAT_OK;
                  res_in.data        = word_to_data(ram_rdata);
                  res_in.found_index = index_out(pend_addr_ff);
                  state_in           = S_RESP;
               end else begin
                  at_in    = pend_addr_ff;
                  ptr_in   = pend_addr_ff;
                  issue_in = 1'b1;
                  state_in = S_DEL_SHIFT;
               end
               pend_in = 1'b0;
            end else if (issue_ff) begin
               ram_req.re    = 1'b1;
               ram_req.raddr = ptr_ff;
               pend_in       = 1'b1;
               pend_addr_in  = ptr_ff;
               if (ptr_is_end) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + IDX_W'(1);
               end
            end else begin
               pend_in       = 1'b0;
               res_in.status = STAT_MISS;
               state_in      = S_RESP;
            end
         end

         // Read-out: fetch one element.
         S_RD_ISSUE: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = ptr_ff;
            state_in      = S_RD_OUT;
         end

         // Read-out: hand the element over once the output register is free.
         S_RD_OUT: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = STAT_OK;
               rsp_in.data        = word_to_data(ram_rdata);
               rsp_in.found_index = index_out(ptr_ff);
               rsp_in.count       = count_out(count_ff);
               rsp_in.last        = ptr_is_end;
               if (ptr_is_end) begin
                  state_in = S_IDLE;
               end else begin
                  ptr_in   = ptr_ff + IDX_W'(1);
                  state_in = S_RD_ISSUE;
               end
            end
         end

         // Single response of a request.
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               rsp_in.count = count_out(count_ff);
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and pointers.
   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      at_ff        <= at_in;
      pend_addr_ff <= pend_addr_in;
      word_ff      <= word_in;
      removed_ff   <= removed_in;
      kind_ff      <= kind_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_ff.status;
   assign rsp_if.data        = rsp_ff.data;
   assign rsp_if.found_index = rsp_ff.found_index;
   assign rsp_if.count       = rsp_ff.count;
   assign rsp_if.last        = rsp_ff.last;
   assign stat.idle          = (state_ff == S_IDLE);
   assign stat.count         = count_ff;

endmodule

/* hdl/ordered_list_store.sv */
// Bounded ordered list of signed words held in one single-port-read,
// single-port-write memory.
// The req_if channel takes one request: insert at front, at end or after an
// index, delete from front, from end, at an index or the first match, search
// for the first match, or (read_all set) read out every element.
// The rsp_if channel returns one response per request, or one per element for
// a read-out, with last set on the final one. Each response carries status,
// data, index and the element count after the request.
// Requests are taken one at a time; ready is high only while the sequencer
// is idle. With the receiver ready, how long a request holds the sequencer
// is set by the one memory read port walking the entries, so it grows with
// the element count. The final response becomes valid in the same cycle
// that ready rises again.
// The response sits in an output register, so a new request is taken while
// the last response still waits; a stalled receiver only holds the sequencer
// when it has a further response to hand over.
// Synchronous reset empties the list at once; the memory contents are not
// cleared, since only entries below the count are ever read.
module ordered_list_store (
   input  logic       clock,
   input  logic       reset,
   olst_req_if.sink   req_if,
   olst_rsp_if.source rsp_if
);
   import olst_pkg::*;

   ram_req_type           ram_req;
   logic [DATA_WIDTH-1:0] ram_rdata;
   ctrl_stat_type         stat;

   // Request sequencer and output register.
   olst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata),
      .stat      (stat)
   );

   // Element storage.
   olst_ram #(
      .DEPTH_P (DEPTH),
      .WIDTH_P (DATA_WIDTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   // Shifts never write the entry they are reading in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      ram_req.we && ram_req.re |-> ram_req.waddr != ram_req.raddr)
      else $error("memory read and write collide on one entry");

   // The element count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      stat.count <= CNT_W'(DEPTH))
      else $error("element count above capacity");

   // An accepted request takes the sequencer out of idle.
   assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("second request taken while one is in progress");

   // The memory is written only while a request is in progress.
   assert property (@(posedge clock) disable iff (reset)
      ram_req.we |-> !stat.idle)
      else $error("memory written while idle");

endmodule
